// ----- sv/sfd_pkg.sv -----
// sfd_pkg: shared types and constants of the frame decoder
// used by sfd_ctrl, sfd_datapath and sbus_frame_decoder; no dependencies
package sfd_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int COUNT_SAT  = 26;
    localparam int COUNT_W    = 5;
    localparam int NUM_CH     = 16;
    localparam int CH_W       = 4;
    localparam int RAW_W      = 11;
    localparam int MAP_W      = 16;
    localparam int STORE_W    = FRAME_LEN * 8;
    localparam int PROD_W     = MAP_W + RAW_W + 1;
    localparam int FRAC_W     = 12;

    localparam logic [7:0] START_MARK = 8'h0F;

    // flag byte bit positions
    localparam int FLAG_CH17 = 0;
    localparam int FLAG_CH18 = 1;
    localparam int FLAG_LOST = 2;
    localparam int FLAG_FS   = 3;

    localparam logic signed [MAP_W-1:0] GAIN_RESET   = 16'sd4096;
    localparam logic signed [MAP_W-1:0] OFFSET_RESET = 16'sd0;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_IDLE  = 2'd1,
        ACT_ERROR = 2'd2,
        ACT_RSVD  = 2'd3
    } sfd_action_t;

    typedef enum logic [1:0] {
        REG_MAP_GAIN   = 2'd0,
        REG_MAP_OFFSET = 2'd1
    } sfd_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_MAP,
        ST_SEND
    } sfd_state_t;

    typedef struct packed {
        logic byte_wr;
        logic count_clr;
        logic frame_start;
        logic mul_load;
        logic map_load;
        logic ch_next;
    } sfd_cmd_t;

    typedef struct packed {
        logic frame_full;
        logic ch_last;
    } sfd_status_t;

endpackage

// ----- sv/sfd_ctrl.sv -----
// sfd_ctrl: sequencer of the frame decoder, input handshake and result steps
// depends on sfd_pkg
module sfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_action,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sfd_pkg::sfd_status_t status,
    output sfd_pkg::sfd_cmd_t   cmd
);
    import sfd_pkg::*;

    sfd_state_t state_reg;
    sfd_state_t state_next;
    logic       in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        in_take    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                in_take  = in_valid;
                if (in_take)
                begin
                    case (sfd_action_t'(in_action))
                        ACT_BYTE:
                        begin
                            cmd.byte_wr = 1'b1;
                        end
                        ACT_IDLE:
                        begin
                            cmd.count_clr = 1'b1;
                            if (status.frame_full)
                            begin
                                cmd.frame_start = 1'b1;
                                state_next      = ST_MUL;
                            end
                        end
                        ACT_ERROR:
                        begin
                            cmd.count_clr = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MAP;
            end
            ST_MAP:
            begin
                cmd.map_load = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.ch_next = 1'b1;
                    state_next  = status.ch_last ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sfd_datapath.sv -----
// sfd_datapath: frame store, byte count, config registers, unpack and gain mapping
// depends on sfd_pkg; driven by sfd_ctrl commands
module sfd_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sfd_pkg::sfd_cmd_t          cmd,
    output sfd_pkg::sfd_status_t       status,
    input  logic [7:0]                 rx_byte,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    output logic [sfd_pkg::CH_W-1:0]   channel_index,
    output logic [sfd_pkg::RAW_W-1:0]  raw_value,
    output logic [sfd_pkg::MAP_W-1:0]  mapped_value,
    output logic [3:0]                 flags,
    output logic                       frame_ok,
    output logic                       last
);
    import sfd_pkg::*;

    logic [STORE_W-1:0]       store_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [MAP_W-1:0]  gain_reg;
    logic signed [MAP_W-1:0]  offset_reg;
    logic [3:0]               flags_reg;
    logic                     ok_reg;
    logic [CH_W-1:0]          ch_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAP_W-1:0]         mapped_reg;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [MAP_W-1:0]  scaled;
    logic signed [MAP_W:0]    sum;
    logic [MAP_W-1:0]         mapped_next;
    logic [7:0]               flag_byte;
    logic                     ok_next;
    logic [RAW_W-1:0]         raw_cur;

    assign flag_byte = store_reg[23*8 +: 8];
    assign ok_next   = (store_reg[7:0] == START_MARK)
                    && (store_reg[24*8 +: 8] == 8'd0)
                    && !flag_byte[FLAG_LOST] && !flag_byte[FLAG_FS];
    assign raw_cur   = store_reg[8 +: RAW_W];

    assign prod_next = PROD_W'($signed({{(PROD_W-MAP_W){gain_reg[MAP_W-1]}}, gain_reg})
                     * $signed({{(PROD_W-RAW_W){1'b0}}, raw_cur}));
    assign scaled    = prod_reg[FRAC_W +: MAP_W];
    assign sum       = {scaled[MAP_W-1], scaled} + {offset_reg[MAP_W-1], offset_reg};

    always_comb
    begin
        if (sum[MAP_W] != sum[MAP_W-1])
        begin
            mapped_next = sum[MAP_W] ? {1'b1, {(MAP_W-1){1'b0}}} : {1'b0, {(MAP_W-1){1'b1}}};
        end
        else
        begin
            mapped_next = sum[MAP_W-1:0];
        end
    end

    // control state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ch_reg     <= '0;
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else
        begin
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.byte_wr && (count_reg < COUNT_W'(COUNT_SAT)))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.frame_start)
            begin
                ch_reg <= '0;
            end
            else if (cmd.ch_next)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (sfd_reg_idx_t'(cfg_index))
                    REG_MAP_GAIN:   gain_reg   <= $signed(cfg_data);
                    REG_MAP_OFFSET: offset_reg <= $signed(cfg_data);
                    default:        gain_reg   <= gain_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr && (count_reg < COUNT_W'(FRAME_LEN)))
        begin
            store_reg <= {rx_byte, store_reg[STORE_W-1:8]};
        end
        else if (cmd.ch_next)
        begin
            store_reg <= store_reg >> RAW_W;
        end
        if (cmd.frame_start)
        begin
            flags_reg <= flag_byte[3:0];
            ok_reg    <= ok_next;
        end
        if (cmd.mul_load)
        begin
            raw_reg  <= raw_cur;
            prod_reg <= prod_next;
        end
        if (cmd.map_load)
        begin
            mapped_reg <= mapped_next;
        end
    end

    assign status.frame_full = (count_reg == COUNT_W'(FRAME_LEN));
    assign status.ch_last    = (ch_reg == CH_W'(NUM_CH - 1));

    assign channel_index = ch_reg;
    assign raw_value     = raw_reg;
    assign mapped_value  = mapped_reg;
    assign flags         = flags_reg;
    assign frame_ok      = ok_reg;
    assign last          = status.ch_last;

endmodule

// ----- sv/sbus_frame_decoder.sv -----
// sbus_frame_decoder: top level, 16-channel serial-bus frame decoder
// depends on sfd_pkg, sfd_ctrl and sfd_datapath
//
// Takes one item per cycle while waiting for a frame: a received byte, a line
// idle or a line error. An idle after exactly 25 bytes decodes the frame and
// sends 16 results, one per channel; each is multiplied, then mapped and
// saturated, then presented and held while m_axis_tready is low; the
// sequencer handles one result at a time, and no input is taken until the last
// result has gone. Config writes are always taken.
module sbus_frame_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // raw_value, mapped_value, digital_ch17, digital_ch18, lost_frame, fail_safe, frame_ok
    output logic [31:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // channel_index
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sfd_pkg::*;

    sfd_cmd_t           cmd;
    sfd_status_t        status;
    logic [CH_W-1:0]    channel_index;
    logic [RAW_W-1:0]   raw_value;
    logic [MAP_W-1:0]   mapped_value;
    logic [3:0]         flags;
    logic               frame_ok;
    logic               last;

    assign cfg_ready = 1'b1;

    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (s_axis_tdata),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .channel_index (channel_index),
        .raw_value     (raw_value),
        .mapped_value  (mapped_value),
        .flags         (flags),
        .frame_ok      (frame_ok),
        .last          (last)
    );

    assign m_axis_tdata = {frame_ok, flags[FLAG_FS], flags[FLAG_LOST],
                           flags[FLAG_CH18], flags[FLAG_CH17], mapped_value, raw_value};
    assign m_axis_tuser = channel_index;
    assign m_axis_tlast = last;

endmodule
